### rtl/core/pcrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrf_pkg
// Operation and status codes, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pcrf_pkg;

  typedef enum logic [3:0] {
    OP_ALLOC   = 4'd0,
    OP_MWRITE  = 4'd1,
    OP_MREAD   = 4'd2,
    OP_SWRITE  = 4'd3,
    OP_SREAD   = 4'd4,
    OP_CLOSE_M = 4'd5,
    OP_CLOSE_S = 4'd6,
    OP_SOPEN   = 4'd7,
    OP_LOCK    = 4'd8,
    OP_QUERY   = 4'd9
  } op_e;

  typedef enum logic [2:0] {
    STS_OK    = 3'd0,
    STS_BAD   = 3'd1,
    STS_BLOCK = 3'd2,
    STS_PEER  = 3'd3,
    STS_FULL  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CS_IDLE   = 2'd0,
    CS_EXEC   = 2'd1,
    CS_RDWAIT = 2'd2
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;      // latch the incoming word
    logic commit;       // apply the operation to the pair table and rings
    logic load_result;  // load the output register from the decoded result
    logic load_read;    // load the output register with the ring read data
  } pcrf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rd_hit;       // operation is a read that will take a byte
    logic out_free;     // output register can take a result this cycle
  } pcrf_sts_t;

endpackage

### rtl/core/pcrf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrf_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module pcrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/pcrf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrf_ctrl
// Controller: takes one word, has it executed, and waits for the ring read
// data where a read takes a byte.
// ----------------------------------------------------------------------------
module pcrf_ctrl
  import pcrf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pcrf_sts_t sts_i,
  output pcrf_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = CS_EXEC;
        end
      end
      CS_EXEC: begin
        if (sts_i.rd_hit) begin
          cmd_o.commit = 1'b1;
          state_d      = CS_RDWAIT;
        end else if (sts_i.out_free) begin
          cmd_o.commit      = 1'b1;
          cmd_o.load_result = 1'b1;
          state_d           = CS_IDLE;
        end
      end
      CS_RDWAIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_read = 1'b1;
          state_d         = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/pcrf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrf_dp
// Datapath: input register, pair table with ring pointers, the two ring
// memories and the output register.
// ----------------------------------------------------------------------------
module pcrf_dp
  import pcrf_pkg::*;
#(
  parameter int PAIRS      = 8,
  parameter int RING_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pcrf_cmd_t  cmd_i,
  output pcrf_sts_t  sts_o,
  input  logic [3:0] operation_i,
  input  logic [3:0] pair_index_i,
  input  logic [7:0] data_byte_i,
  input  logic       lock_value_i,
  input  logic       transfer_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] status_o,
  output logic [3:0] granted_index_o,
  output logic [7:0] read_byte_o,
  output logic       pair_used_o,
  output logic       pair_unlocked_o,
  output logic       transfer_end_out_o
);

  localparam int PW = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int AW = $clog2(RING_DEPTH);
  localparam int MemDepth = PAIRS * RING_DEPTH;
  localparam int MW = $clog2(MemDepth);
  localparam logic [AW-1:0] PtrLast = AW'(RING_DEPTH - 1);
  localparam logic [MW-1:0] RingStride = MW'(RING_DEPTH);
  localparam logic [4:0] PairsLim = 5'(PAIRS);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == PtrLast) ? '0 : p + AW'(1);
  endfunction

  // Captured word.
  op_e        op_q;
  logic [3:0] idx_q;
  logic [7:0] data_q;
  logic       lockv_q;
  logic       tend_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_e'(operation_i);
      idx_q   <= pair_index_i;
      data_q  <= data_byte_i;
      lockv_q <= lock_value_i;
      tend_q  <= transfer_end_i;
    end
  end

  // Pair table.
  logic [PAIRS-1:0] in_use_q, locked_q, mopen_q, sopen_q;
  logic [AW-1:0]    dr_q [PAIRS];
  logic [AW-1:0]    dw_q [PAIRS];
  logic [AW-1:0]    ur_q [PAIRS];
  logic [AW-1:0]    uw_q [PAIRS];

  logic          ok_idx;
  logic [PW-1:0] sel;
  logic          cur_used, cur_locked, cur_mopen, cur_sopen;
  logic [AW-1:0] cur_dr, cur_dw, cur_ur, cur_uw;
  logic          down_full, down_empty, up_full, up_empty;
  logic          free_found;
  logic [PW-1:0] free_idx;

  assign ok_idx     = {1'b0, idx_q} < PairsLim;
  assign sel        = ok_idx ? idx_q[PW-1:0] : '0;
  assign cur_used   = in_use_q[sel];
  assign cur_locked = locked_q[sel];
  assign cur_mopen  = mopen_q[sel];
  assign cur_sopen  = sopen_q[sel];
  assign cur_dr     = dr_q[sel];
  assign cur_dw     = dw_q[sel];
  assign cur_ur     = ur_q[sel];
  assign cur_uw     = uw_q[sel];
  assign down_full  = ptr_inc(cur_dw) == cur_dr;
  assign down_empty = cur_dw == cur_dr;
  assign up_full    = ptr_inc(cur_uw) == cur_ur;
  assign up_empty   = cur_uw == cur_ur;

  // Lowest free pair: the last assignment in the descending loop wins.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int p = PAIRS - 1; p >= 0; p--) begin
      if (!in_use_q[p]) begin
        free_found = 1'b1;
        free_idx   = PW'(p);
      end
    end
  end

  // Decode of the operation into actions and a result.
  status_e    res_status;
  logic [3:0] res_granted;
  logic       res_used, res_unlocked;
  logic       wr_down, wr_up, rd_down, rd_up;
  logic       do_alloc, do_close_m, do_close_s, do_sopen, do_lock;

  always_comb begin
    res_status   = STS_OK;
    res_granted  = '0;
    res_used     = 1'b0;
    res_unlocked = 1'b0;
    wr_down      = 1'b0;
    wr_up        = 1'b0;
    rd_down      = 1'b0;
    rd_up        = 1'b0;
    do_alloc     = 1'b0;
    do_close_m   = 1'b0;
    do_close_s   = 1'b0;
    do_sopen     = 1'b0;
    do_lock      = 1'b0;
    unique case (op_q)
      OP_ALLOC: begin
        if (free_found) begin
          do_alloc    = 1'b1;
          res_granted = 4'(free_idx);
        end else begin
          res_status = STS_FULL;
        end
      end
      OP_MWRITE: begin
        if (!ok_idx || !cur_used) res_status = STS_BAD;
        else if (down_full) res_status = cur_sopen ? STS_BLOCK : STS_PEER;
        else wr_down = 1'b1;
      end
      OP_MREAD: begin
        if (!ok_idx || !cur_used) res_status = STS_BAD;
        else if (up_empty) res_status = cur_sopen ? STS_BLOCK : STS_PEER;
        else rd_up = 1'b1;
      end
      OP_SWRITE: begin
        if (!ok_idx || !cur_used) res_status = STS_BAD;
        else if (up_full) res_status = cur_mopen ? STS_BLOCK : STS_PEER;
        else wr_up = 1'b1;
      end
      OP_SREAD: begin
        if (!ok_idx || !cur_used) res_status = STS_BAD;
        else if (down_empty) res_status = cur_mopen ? STS_BLOCK : STS_PEER;
        else rd_down = 1'b1;
      end
      OP_CLOSE_M: begin
        if (!ok_idx) res_status = STS_BAD;
        else do_close_m = 1'b1;
      end
      OP_CLOSE_S: begin
        if (!ok_idx) res_status = STS_BAD;
        else do_close_s = 1'b1;
      end
      OP_SOPEN: begin
        if (!ok_idx) res_status = STS_BAD;
        else do_sopen = 1'b1;
      end
      OP_LOCK: begin
        if (!ok_idx) res_status = STS_BAD;
        else do_lock = 1'b1;
      end
      OP_QUERY: begin
        if (!ok_idx) begin
          res_status = STS_BAD;
        end else begin
          res_used     = cur_used;
          res_unlocked = cur_used & ~cur_locked;
        end
      end
      default: begin
        res_status = STS_BAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      locked_q <= '0;
      mopen_q  <= '0;
      sopen_q  <= '0;
      for (int p = 0; p < PAIRS; p++) begin
        dr_q[p] <= '0;
        dw_q[p] <= '0;
        ur_q[p] <= '0;
        uw_q[p] <= '0;
      end
    end else if (cmd_i.commit) begin
      if (do_alloc) begin
        dr_q[free_idx]     <= '0;
        dw_q[free_idx]     <= '0;
        ur_q[free_idx]     <= '0;
        uw_q[free_idx]     <= '0;
        in_use_q[free_idx] <= 1'b1;
        locked_q[free_idx] <= 1'b1;
        mopen_q[free_idx]  <= 1'b1;
        sopen_q[free_idx]  <= 1'b0;
      end
      if (wr_down) dw_q[sel] <= ptr_inc(cur_dw);
      if (rd_down) dr_q[sel] <= ptr_inc(cur_dr);
      if (wr_up)   uw_q[sel] <= ptr_inc(cur_uw);
      if (rd_up)   ur_q[sel] <= ptr_inc(cur_ur);
      if (do_close_m) begin
        mopen_q[sel] <= 1'b0;
        if (!cur_sopen) in_use_q[sel] <= 1'b0;
      end
      if (do_close_s) begin
        sopen_q[sel] <= 1'b0;
        if (!cur_mopen) in_use_q[sel] <= 1'b0;
      end
      if (do_sopen) sopen_q[sel] <= 1'b1;
      if (do_lock)  locked_q[sel] <= lockv_q;
    end
  end

  // Ring memories: each pair owns RING_DEPTH consecutive entries.
  logic [MW-1:0] base;
  logic [MW-1:0] down_addr, up_addr;
  logic [7:0]    down_rdata, up_rdata;

  assign base      = MW'(sel) * RingStride;
  assign down_addr = base + MW'(wr_down ? cur_dw : cur_dr);
  assign up_addr   = base + MW'(wr_up ? cur_uw : cur_ur);

  pcrf_ram #(
    .WIDTH(8),
    .DEPTH(MemDepth)
  ) u_down_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.commit & wr_down),
    .re_i   (cmd_i.commit & rd_down),
    .addr_i (down_addr),
    .wdata_i(data_q),
    .rdata_o(down_rdata)
  );

  pcrf_ram #(
    .WIDTH(8),
    .DEPTH(MemDepth)
  ) u_up_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.commit & wr_up),
    .re_i   (cmd_i.commit & rd_up),
    .addr_i (up_addr),
    .wdata_i(data_q),
    .rdata_o(up_rdata)
  );

  // Output register.
  logic       rd_up_q;
  logic       out_valid_q;
  logic [2:0] status_q;
  logic [3:0] granted_q;
  logic [7:0] rbyte_q;
  logic       used_q, unlocked_q, tend_out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rd_up_q <= rd_up;
    end
    if (cmd_i.load_result) begin
      status_q   <= res_status;
      granted_q  <= res_granted;
      rbyte_q    <= '0;
      used_q     <= res_used;
      unlocked_q <= res_unlocked;
      tend_out_q <= tend_q;
    end else if (cmd_i.load_read) begin
      status_q   <= STS_OK;
      granted_q  <= '0;
      rbyte_q    <= rd_up_q ? up_rdata : down_rdata;
      used_q     <= 1'b0;
      unlocked_q <= 1'b0;
      tend_out_q <= tend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_result || cmd_i.load_read) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.rd_hit   = rd_down | rd_up;
  assign sts_o.out_free = ~out_valid_q | out_ready_i;

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign granted_index_o    = granted_q;
  assign read_byte_o        = rbyte_q;
  assign pair_used_o        = used_q;
  assign pair_unlocked_o    = unlocked_q;
  assign transfer_end_out_o = tend_out_q;

endmodule

### rtl/core/paired_channel_ring_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paired_channel_ring_fifo
// Table of channel pairs, each with a master-to-slave and a slave-to-master
// byte ring, driven by one operation word at a time.
// ----------------------------------------------------------------------------
// Each input word carries one operation (allocate, byte write or read from
// either end, close either end, open the slave end, set the lock, query) and
// produces exactly one result word. The block works on one word at a time:
// a word is taken in the idle state and executed in the execute state;
// a successful byte read then waits in a read-wait state for the ring
// memory, which has a registered read port, before it loads its byte. The
// result sits in an output register, so the next word is taken while the
// previous result is still waiting; only a result that cannot enter the
// output register holds the controller back. A ring keeps one slot empty and
// therefore holds at most RING_DEPTH-1 bytes. A full ring on write, or an
// empty ring on read, reports "would block" while the other end is open and
// "peer closed" once it has shut. The rings need no clearing after reset.
// ----------------------------------------------------------------------------
module paired_channel_ring_fifo
  import pcrf_pkg::*;
#(
  parameter int PAIRS      = 8,
  parameter int RING_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [3:0] operation_i,
  input  logic [3:0] pair_index_i,
  input  logic [7:0] data_byte_i,
  input  logic       lock_value_i,
  input  logic       transfer_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] status_o,
  output logic [3:0] granted_index_o,
  output logic [7:0] read_byte_o,
  output logic       pair_used_o,
  output logic       pair_unlocked_o,
  output logic       transfer_end_out_o
);

  // The controller sequences each word; the datapath holds the pair table, rings and output register.
  pcrf_cmd_t cmd;
  pcrf_sts_t sts;

  pcrf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  pcrf_dp #(
    .PAIRS     (PAIRS),
    .RING_DEPTH(RING_DEPTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .operation_i       (operation_i),
    .pair_index_i      (pair_index_i),
    .data_byte_i       (data_byte_i),
    .lock_value_i      (lock_value_i),
    .transfer_end_i    (transfer_end_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .granted_index_o   (granted_index_o),
    .read_byte_o       (read_byte_o),
    .pair_used_o       (pair_used_o),
    .pair_unlocked_o   (pair_unlocked_o),
    .transfer_end_out_o(transfer_end_out_o)
  );

endmodule

### test/paired_channel_ring_fifo_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paired_channel_ring_fifo_tb
// Self-checking bench for the channel pair table with its two byte rings.
// ----------------------------------------------------------------------------
// A short directed list walks reset state, allocation, both ends of both
// rings, the error codes and freeing a pair. Random traffic follows: working
// sessions on allocated pairs, runs that fill a ring to the brim and then
// shut the peer, and malformed words. Each result word is checked, with random
// gaps on both channels, against a listed value or cycle-free pair table model.
// ----------------------------------------------------------------------------
module paired_channel_ring_fifo_tb;
  import pcrf_pkg::*;

  localparam int NPAIRS       = 8;
  localparam int DEPTH        = 256;
  localparam int RANDOM_ITEMS = 1650;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int TAIL_CYCLES  = 16;

  localparam logic [3:0] OP_UNKNOWN_LO = 4'd10;
  localparam logic [3:0] OP_UNKNOWN_HI = 4'd15;

  typedef struct packed {
    status_e    status;
    logic [3:0] granted;
    logic [7:0] rbyte;
    logic       used;
    logic       unlocked;
    logic       tend;
  } fifo_result_t;

  typedef struct {
    logic [3:0]   op;
    logic [3:0]   idx;
    logic [7:0]   data;
    logic         lockv;
    logic         tend;
    bit           fixed;
    fifo_result_t res;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [3:0] op_in = '0;
  logic [3:0] idx_in = '0;
  logic [7:0] data_in = '0;
  logic       lock_in = 1'b0;
  logic       tend_in = 1'b0;
  logic       out_ready = 1'b0;
  bit           in_fixed = 1'b0;
  fifo_result_t in_fixed_res = '0;

  logic       in_ready;
  logic       out_valid;
  logic [2:0] status_out;
  logic [3:0] granted_out;
  logic [7:0] read_byte_out;
  logic       used_out;
  logic       unlocked_out;
  logic       tend_out;

  paired_channel_ring_fifo #(
    .PAIRS      (NPAIRS),
    .RING_DEPTH (DEPTH)
  ) dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .operation_i        (op_in),
    .pair_index_i       (idx_in),
    .data_byte_i        (data_in),
    .lock_value_i       (lock_in),
    .transfer_end_i     (tend_in),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .status_o           (status_out),
    .granted_index_o    (granted_out),
    .read_byte_o        (read_byte_out),
    .pair_used_o        (used_out),
    .pair_unlocked_o    (unlocked_out),
    .transfer_end_out_o (tend_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Model of the pair table.
  bit         pair_live   [NPAIRS];
  bit         pair_locked [NPAIRS];
  bit         m_side_open [NPAIRS];
  bit         s_side_open [NPAIRS];
  logic [7:0] m2s_ring    [NPAIRS][DEPTH];
  logic [7:0] s2m_ring    [NPAIRS][DEPTH];
  int         m2s_rd      [NPAIRS];
  int         m2s_wr      [NPAIRS];
  int         s2m_rd      [NPAIRS];
  int         s2m_wr      [NPAIRS];

  fifo_result_t pending_results[$];
  stim_row_t    directed_rows[25];
  int           fails = 0;
  int           items_sent = 0;
  int           cycles = 0;
  int           tx_stretch = 0;
  bit           tx_calm = 1'b0;
  int           rx_stretch = 0;
  bit           rx_calm = 1'b0;

  function automatic status_e ring_push(bit up_dir, int p, logic [7:0] b);
    int  rd;
    int  wr;
    bit  peer;
    rd   = up_dir ? s2m_rd[p] : m2s_rd[p];
    wr   = up_dir ? s2m_wr[p] : m2s_wr[p];
    peer = up_dir ? m_side_open[p] : s_side_open[p];
    if ((wr + DEPTH - rd) % DEPTH >= DEPTH - 1) return peer ? STS_BLOCK : STS_PEER;
    if (up_dir) begin
      s2m_ring[p][wr] = b;
      s2m_wr[p] = (wr + 1) % DEPTH;
    end else begin
      m2s_ring[p][wr] = b;
      m2s_wr[p] = (wr + 1) % DEPTH;
    end
    return STS_OK;
  endfunction

  function automatic status_e ring_pop(bit up_dir, int p, output logic [7:0] b);
    int rd;
    int wr;
    bit peer;
    b    = '0;
    rd   = up_dir ? s2m_rd[p] : m2s_rd[p];
    wr   = up_dir ? s2m_wr[p] : m2s_wr[p];
    peer = up_dir ? s_side_open[p] : m_side_open[p];
    if (rd == wr) return peer ? STS_BLOCK : STS_PEER;
    if (up_dir) begin
      b = s2m_ring[p][rd];
      s2m_rd[p] = (rd + 1) % DEPTH;
    end else begin
      b = m2s_ring[p][rd];
      m2s_rd[p] = (rd + 1) % DEPTH;
    end
    return STS_OK;
  endfunction

  function automatic fifo_result_t apply_operation(logic [3:0] op, logic [3:0] idx,
                                                   logic [7:0] data, logic lockv,
                                                   logic tend);
    fifo_result_t r;
    int           p;
    bit           found;
    logic [7:0]   b;
    r = '0;
    r.status = STS_OK;
    r.tend = tend;
    p = int'(idx);
    b = '0;
    if (op == OP_ALLOC) begin
      r.status = STS_FULL;
      found = 1'b0;
      for (int q = 0; q < NPAIRS; q++) begin
        if (!found && !pair_live[q]) begin
          found = 1'b1;
          m2s_rd[q] = 0;
          m2s_wr[q] = 0;
          s2m_rd[q] = 0;
          s2m_wr[q] = 0;
          pair_live[q] = 1'b1;
          pair_locked[q] = 1'b1;
          m_side_open[q] = 1'b1;
          s_side_open[q] = 1'b0;
          r.granted = 4'(q);
          r.status = STS_OK;
        end
      end
    end else if (op > OP_QUERY || p >= NPAIRS) begin
      r.status = STS_BAD;
    end else if (op <= OP_SREAD) begin
      if (!pair_live[p]) begin
        r.status = STS_BAD;
      end else begin
        case (op_e'(op))
          OP_MWRITE: r.status = ring_push(1'b0, p, data);
          OP_MREAD:  r.status = ring_pop(1'b1, p, b);
          OP_SWRITE: r.status = ring_push(1'b1, p, data);
          default:   r.status = ring_pop(1'b0, p, b);
        endcase
        if (r.status == STS_OK) r.rbyte = b;
      end
    end else begin
      case (op_e'(op))
        OP_CLOSE_M: begin
          m_side_open[p] = 1'b0;
          if (!s_side_open[p]) pair_live[p] = 1'b0;
        end
        OP_CLOSE_S: begin
          s_side_open[p] = 1'b0;
          if (!m_side_open[p]) pair_live[p] = 1'b0;
        end
        OP_SOPEN: s_side_open[p] = 1'b1;
        OP_LOCK:  pair_locked[p] = lockv;
        default: begin
          r.used = pair_live[p];
          r.unlocked = pair_live[p] && !pair_locked[p];
        end
      endcase
    end
    return r;
  endfunction

  function automatic stim_row_t row(logic [3:0] op, logic [3:0] idx, logic [7:0] data,
                                    logic lockv, logic tend, bit fixed,
                                    status_e st = STS_OK, logic [3:0] gnt = '0,
                                    logic used = 1'b0, logic unl = 1'b0);
    stim_row_t s;
    s.op = op;
    s.idx = idx;
    s.data = data;
    s.lockv = lockv;
    s.tend = tend;
    s.fixed = fixed;
    s.res = '0;
    s.res.status = st;
    s.res.granted = gnt;
    s.res.used = used;
    s.res.unlocked = unl;
    s.res.tend = tend;
    return s;
  endfunction

  // Alternates stretches with no idling and stretches of random gaps.
  function automatic int draw_gap(inout int stretch, inout bit calm);
    if (stretch == 0) begin
      calm = ($urandom_range(0, 2) == 0);
      stretch = $urandom_range(10, 40);
    end
    stretch--;
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // Offers one word and returns at the edge that accepts it.
  task automatic send_word(logic [3:0] op, logic [3:0] idx, logic [7:0] data,
                           logic lockv, logic tend, bit fixed, fifo_result_t res);
    int gap;
    gap = draw_gap(tx_stretch, tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    op_in        <= op;
    idx_in       <= idx;
    data_in      <= data;
    lock_in      <= lockv;
    tend_in      <= tend;
    in_fixed     <= fixed;
    in_fixed_res <= res;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_rand(logic [3:0] op, int p);
    send_word(op, 4'(p), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Works one pair with a mix of byte traffic and control words.
  task automatic run_session(int p);
    int n;
    int w;
    send_rand(OP_ALLOC, p);
    if ($urandom_range(0, 9) < 7) send_rand(OP_SOPEN, p);
    n = $urandom_range(2, 24);
    repeat (n) begin
      w = $urandom_range(0, 99);
      if (w < 30)      send_rand(OP_MWRITE, p);
      else if (w < 55) send_rand(OP_SREAD, p);
      else if (w < 75) send_rand(OP_SWRITE, p);
      else if (w < 90) send_rand(OP_MREAD, p);
      else if (w < 95) send_rand(OP_LOCK, p);
      else             send_rand(OP_QUERY, p);
    end
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1) == 1) begin
        send_rand(OP_CLOSE_M, p);
        send_rand(OP_CLOSE_S, p);
      end else begin
        send_rand(OP_CLOSE_S, p);
        send_rand(OP_CLOSE_M, p);
      end
    end
  endtask

  // Recycles a pair, fills one ring past full, shuts the peer, then reads back.
  task automatic fill_ring(bit up_dir, int p);
    send_rand(OP_CLOSE_M, p);
    send_rand(OP_CLOSE_S, p);
    send_rand(OP_ALLOC, p);
    send_rand(OP_SOPEN, p);
    repeat (DEPTH) send_rand(up_dir ? OP_SWRITE : OP_MWRITE, p);
    send_rand(up_dir ? OP_CLOSE_M : OP_CLOSE_S, p);
    send_rand(up_dir ? OP_SWRITE : OP_MWRITE, p);
    repeat (20) send_rand(up_dir ? OP_MREAD : OP_SREAD, p);
  endtask

  // Prediction at input acceptance, checking at output acceptance.
  always @(posedge clk) begin
    fifo_result_t want;
    fifo_result_t got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        want = apply_operation(op_in, idx_in, data_in, lock_in, tend_in);
        if (in_fixed) want = in_fixed_res;
        pending_results.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = {status_out, granted_out, read_byte_out, used_out, unlocked_out, tend_out};
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result word st=%0d gnt=%0d byte=%h used=%b unl=%b te=%b",
                   $time, got.status, got.granted, got.rbyte, got.used, got.unlocked,
                   got.tend);
          fails++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected st=%0d gnt=%0d byte=%h used=%b unl=%b te=%b",
                     $time, want.status, want.granted, want.rbyte, want.used,
                     want.unlocked, want.tend);
            $display("%0t:          actual   st=%0d gnt=%0d byte=%h used=%b unl=%b te=%b",
                     $time, got.status, got.granted, got.rbyte, got.used, got.unlocked,
                     got.tend);
            fails++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("paired_channel_ring_fifo verification failed");
      $finish;
    end
  end

  // Result side: a random stall before taking each word.
  initial begin
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = draw_gap(rx_stretch, rx_calm);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int kind;
    int fills_done;
    int p;
    fills_done = 0;
    directed_rows[0]  = row(OP_QUERY,      4'd0,  8'h00, 1'b0, 1'b0, 1'b1, STS_OK);
    directed_rows[1]  = row(OP_MWRITE,     4'd0,  8'hFF, 1'b0, 1'b1, 1'b1, STS_BAD);
    directed_rows[2]  = row(OP_UNKNOWN_HI, 4'd0,  8'h00, 1'b0, 1'b0, 1'b1, STS_BAD);
    directed_rows[3]  = row(OP_QUERY,      4'd15, 8'h00, 1'b0, 1'b1, 1'b1, STS_BAD);
    directed_rows[4]  = row(OP_ALLOC,      4'd15, 8'h00, 1'b0, 1'b0, 1'b1, STS_OK, 4'd0);
    directed_rows[5]  = row(OP_QUERY,      4'd0,  8'h00, 1'b0, 1'b0, 1'b1, STS_OK, 4'd0,
                            1'b1, 1'b0);
    directed_rows[6]  = row(OP_LOCK,       4'd0,  8'h00, 1'b0, 1'b0, 1'b1, STS_OK);
    directed_rows[7]  = row(OP_QUERY,      4'd0,  8'h00, 1'b0, 1'b1, 1'b1, STS_OK, 4'd0,
                            1'b1, 1'b1);
    directed_rows[8]  = row(OP_MREAD,      4'd0,  8'h00, 1'b0, 1'b0, 1'b1, STS_PEER);
    directed_rows[9]  = row(OP_SREAD,      4'd0,  8'h00, 1'b0, 1'b0, 1'b1, STS_BLOCK);
    directed_rows[10] = row(OP_MWRITE,     4'd0,  8'h00, 1'b0, 1'b0, 1'b0);
    directed_rows[11] = row(OP_MWRITE,     4'd0,  8'hFF, 1'b0, 1'b1, 1'b0);
    directed_rows[12] = row(OP_SREAD,      4'd0,  8'h00, 1'b0, 1'b0, 1'b0);
    directed_rows[13] = row(OP_SREAD,      4'd0,  8'h00, 1'b0, 1'b1, 1'b0);
    directed_rows[14] = row(OP_SOPEN,      4'd0,  8'h00, 1'b0, 1'b0, 1'b1, STS_OK);
    directed_rows[15] = row(OP_SWRITE,     4'd0,  8'hA5, 1'b0, 1'b0, 1'b0);
    directed_rows[16] = row(OP_MREAD,      4'd0,  8'h00, 1'b0, 1'b1, 1'b0);
    directed_rows[17] = row(OP_MREAD,      4'd0,  8'h00, 1'b0, 1'b0, 1'b1, STS_BLOCK);
    directed_rows[18] = row(OP_CLOSE_M,    4'd0,  8'h00, 1'b0, 1'b0, 1'b1, STS_OK);
    // A write with the peer shut still goes in while there is room.
    directed_rows[19] = row(OP_SWRITE,     4'd0,  8'h5A, 1'b0, 1'b1, 1'b0);
    directed_rows[20] = row(OP_CLOSE_S,    4'd0,  8'h00, 1'b0, 1'b0, 1'b1, STS_OK);
    directed_rows[21] = row(OP_QUERY,      4'd0,  8'h00, 1'b0, 1'b0, 1'b1, STS_OK);
    directed_rows[22] = row(OP_CLOSE_M,    4'(NPAIRS - 1), 8'h00, 1'b0, 1'b1, 1'b1, STS_OK);
    directed_rows[23] = row(OP_LOCK,       4'(NPAIRS), 8'h00, 1'b1, 1'b0, 1'b1, STS_BAD);
    directed_rows[24] = row(OP_ALLOC,      4'd0,  8'h00, 1'b0, 1'b1, 1'b1, STS_OK, 4'd0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].data,
                directed_rows[i].lockv, directed_rows[i].tend, directed_rows[i].fixed,
                directed_rows[i].res);
    end
    // Hold off until the block has answered every word so far.
    drain();

    // Fill the table; the last request finds no free pair.
    repeat (NPAIRS) send_rand(OP_ALLOC, 0);

    while (items_sent < RANDOM_ITEMS + 25) begin
      kind = $urandom_range(0, 99);
      p = $urandom_range(0, NPAIRS - 1);
      if (fills_done < 2 && kind < 8) begin
        fill_ring(fills_done[0], p);
        fills_done++;
      end else if (kind < 80) begin
        run_session(p);
      end else if (kind < 85) begin
        send_rand(4'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI)),
                  $urandom_range(0, 15));
      end else if (kind < 90) begin
        send_rand(4'($urandom_range(0, OP_QUERY)), $urandom_range(NPAIRS, 15));
      end else if (kind < 96) begin
        send_rand(4'($urandom_range(0, OP_QUERY)), p);
      end else begin
        drain();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("paired_channel_ring_fifo verification clean");
    end else begin
      $display("paired_channel_ring_fifo verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/pcrf_pkg.sv
rtl/core/pcrf_ram.sv
rtl/core/pcrf_ctrl.sv
rtl/core/pcrf_dp.sv
rtl/core/paired_channel_ring_fifo.sv
test/paired_channel_ring_fifo_tb.sv
